/* rtl/tkr_pkg.sv */
// shared types and codes for the top-k count ranker
package tkr_pkg;

  localparam int unsigned CountW = 31;
  localparam int unsigned IdW    = 16;
  localparam int unsigned DateW  = 32;
  localparam int unsigned RankW  = 8;
  localparam int unsigned HeldW  = 9;
  localparam int unsigned LimitW = 9;
  localparam logic [LimitW-1:0] LimitReset = 9'd100;

  typedef enum logic [1:0] {
    FUNC_OFFER = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [IdW-1:0]    id;
    logic [DateW-1:0]  date;
  } entry_t;

  typedef struct packed {
    logic             offer;
    logic             clear;
    entry_t           item;
    logic [RankW-1:0] rank;
  } cell_ctrl_t;

  typedef struct packed {
    logic              accepted;
    logic [RankW-1:0]  position;
    logic [HeldW-1:0]  entries_held;
    logic              read_valid;
    logic [CountW-1:0] read_count;
    logic [IdW-1:0]    read_id;
    logic [DateW-1:0]  read_date;
  } result_t;

endpackage

/* rtl/tkr_if.sv */
// valid/ready channels for requests, results and the limit register
interface tkr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [30:0] post_count;
  logic [15:0] record_id;
  logic [31:0] post_date;
  logic [7:0]  rank;

  modport source (output valid, func, post_count, record_id, post_date, rank, input ready);
  modport sink (input valid, func, post_count, record_id, post_date, rank, output ready);
endinterface

interface tkr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  position;
  logic [8:0]  entries_held;
  logic        read_valid;
  logic [30:0] read_count;
  logic [15:0] read_id;
  logic [31:0] read_date;

  modport source (output valid, accepted, position, entries_held, read_valid, read_count,
                  read_id, read_date, input ready);
  modport sink (input valid, accepted, position, entries_held, read_valid, read_count,
                read_id, read_date, output ready);
endinterface

interface tkr_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] shown_limit;

  modport source (output valid, shown_limit, input ready);
  modport sink (input valid, shown_limit, output ready);
endinterface

/* rtl/top_k_count_ranker_core.sv */
// top-k ranker: row of compare-and-shift cells with a registered result word
// the result word is registered and valid in the cycle after the request word is accepted
// throughput: one word per cycle while the output is ready; the output register takes a new word as the old one leaves
// every cell decides insert, shift or hold in the same cycle from its neighbor's compare
// reset: table empty, limit register at 100; no clearing pass is needed
module top_k_count_ranker_core #(
  parameter int unsigned TOP_ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tkr_in_if.sink    in_i,
  tkr_cfg_if.sink   cfg_i,
  tkr_out_if.source out_o
);
  import tkr_pkg::*;

  localparam int unsigned TW = $clog2(TOP_ENTRIES + 1);
  localparam int unsigned PW = $clog2(TOP_ENTRIES);
  localparam int unsigned CW = (TW > LimitW) ? TW : LimitW;

  logic [LimitW-1:0] limit_q;
  logic [TW-1:0]     total_q, total_d;
  logic              out_valid_q;
  result_t           out_q, out_d;

  logic       in_acc;
  cell_ctrl_t ctrl;
  logic       smaller [TOP_ENTRIES];
  entry_t     entry   [TOP_ENTRIES];
  entry_t     rd_part [TOP_ENTRIES];
  logic       first   [TOP_ENTRIES];

  logic          any_smaller;
  logic [PW-1:0] pos;
  entry_t        rd_data;
  logic          rd_ok;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign ctrl.offer      = in_acc && (in_i.func == FUNC_OFFER);
  assign ctrl.clear      = in_acc && (in_i.func == FUNC_CLEAR);
  assign ctrl.item.count = in_i.post_count;
  assign ctrl.item.id    = in_i.record_id;
  assign ctrl.item.date  = in_i.post_date;
  assign ctrl.rank       = in_i.rank;

  for (genvar g = 0; g < TOP_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      tkr_cell #(.Index(g)) u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i         (ctrl),
        .prev_entry_i   ('0),
        .prev_smaller_i (1'b0),
        .smaller_o      (smaller[g]),
        .entry_o        (entry[g]),
        .read_o         (rd_part[g])
      );
      assign first[g] = smaller[g];
    end else begin : g_body
      tkr_cell #(.Index(g)) u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i         (ctrl),
        .prev_entry_i   (entry[g-1]),
        .prev_smaller_i (smaller[g-1]),
        .smaller_o      (smaller[g]),
        .entry_o        (entry[g]),
        .read_o         (rd_part[g])
      );
      assign first[g] = smaller[g] && !smaller[g-1];
    end
  end

  // compare flags form a thermometer, so the insert point is one-hot
  always_comb begin
    any_smaller = 1'b0;
    pos         = '0;
    rd_data     = '0;
    for (int i = 0; i < TOP_ENTRIES; i++) begin
      any_smaller = any_smaller | smaller[i];
      pos         = pos | (first[i] ? PW'(i) : '0);
      rd_data     = rd_data | rd_part[i];
    end
  end

  assign rd_ok = (CW'(in_i.rank) < CW'(total_q)) && (CW'(in_i.rank) < CW'(limit_q));

  always_comb begin
    total_d = total_q;
    out_d   = '0;
    case (in_i.func)
      FUNC_OFFER: begin
        if (any_smaller) begin
          out_d.accepted = 1'b1;
          out_d.position = RankW'(pos);
          if (total_q < TW'(TOP_ENTRIES)) begin
            total_d = total_q + 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (rd_ok) begin
          out_d.read_valid = 1'b1;
          out_d.read_count = rd_data.count;
          out_d.read_id    = rd_data.id;
          out_d.read_date  = rd_data.date;
        end
      end
      FUNC_CLEAR: begin
        total_d = '0;
      end
      default: begin
        total_d = total_q;
      end
    endcase
    out_d.entries_held = HeldW'(total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.shown_limit;
      end
      if (in_acc) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_q.accepted;
  assign out_o.position     = out_q.position;
  assign out_o.entries_held = out_q.entries_held;
  assign out_o.read_valid   = out_q.read_valid;
  assign out_o.read_count   = out_q.read_count;
  assign out_o.read_id      = out_q.read_id;
  assign out_o.read_date    = out_q.read_date;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(TOP_ENTRIES))
    else $error("entry total beyond table depth");

  a_offer_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func == FUNC_OFFER) && (in_i.post_count != '0)
      && (total_q < TW'(TOP_ENTRIES)) |=> out_valid_q && out_q.accepted)
    else $error("offer rejected while table had room");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func == FUNC_CLEAR) |=> (total_q == '0) && (entry[0].count == '0))
    else $error("clear left entries behind");

  a_read_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.read_valid |-> out_q.read_count != '0)
    else $error("valid read returned an empty slot");
`endif

endmodule

/* rtl/tkr_cell.sv */
// one rank slot: compare against offered word and shift or insert
module tkr_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkr_pkg::cell_ctrl_t ctrl_i,
  input  tkr_pkg::entry_t     prev_entry_i,
  input  logic                prev_smaller_i,
  output logic                smaller_o,
  output tkr_pkg::entry_t     entry_o,
  output tkr_pkg::entry_t     read_o
);
  import tkr_pkg::*;

  logic [CountW-1:0] count_q;
  logic [IdW-1:0]    id_q;
  logic [DateW-1:0]  date_q;
  entry_t            load;
  logic              take;

  // empty slots hold count zero, so they always rank below any offer with a nonzero count
  assign smaller_o = count_q < ctrl_i.item.count;
  assign take      = ctrl_i.offer && smaller_o;
  assign load      = prev_smaller_i ? prev_entry_i : ctrl_i.item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (take) begin
      count_q <= load.count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      id_q   <= load.id;
      date_q <= load.date;
    end
  end

  assign entry_o = '{count: count_q, id: id_q, date: date_q};
  assign read_o  = (32'(ctrl_i.rank) == Index) ? entry_o : '0;

endmodule
